FILE: rtl/hwdf_pkg.sv
// ----------------------------------------------------------------------------
// hwdf_pkg
// Shared constants and types of the hashed word dedup filter.
// ----------------------------------------------------------------------------
package hwdf_pkg;

  localparam int BITMAP_BITS  = 4096;
  localparam int MAX_WORD_LEN = 255;

  localparam int HASH_W = 64;
  localparam int LEN_W  = 8;
  localparam int BYTE_W = 8;

  localparam logic [HASH_W-1:0] HASH_SEED = HASH_W'(5381);
  localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(MAX_WORD_LEN);

  localparam int BM_ROWS  = 64;
  localparam int ROW_BITS = BITMAP_BITS / BM_ROWS;
  localparam int IDX_W    = $clog2(BITMAP_BITS);
  localparam int COL_W    = $clog2(ROW_BITS);
  localparam int ROW_W    = IDX_W - COL_W;

  localparam int OUT_W  = HASH_W + LEN_W + 2;
  localparam int TOUT_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [BYTE_W-1:0] CH_0 = 8'h30;
  localparam logic [BYTE_W-1:0] CH_9 = 8'h39;
  localparam logic [BYTE_W-1:0] CH_A = 8'h41;
  localparam logic [BYTE_W-1:0] CH_Z = 8'h5a;
  localparam logic [BYTE_W-1:0] CH_LA = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LZ = 8'h7a;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } bm_req_t;

  typedef struct packed {
    logic valid;
    logic was_set;
  } bm_rsp_t;

  function automatic logic is_word_char(input logic [BYTE_W-1:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_A && c <= CH_Z) ||
           (c >= CH_LA && c <= CH_LZ);
  endfunction

endpackage

FILE: rtl/hwdf_bitmap.sv
// ----------------------------------------------------------------------------
// hwdf_bitmap
// Seen-bitmap with one test-and-set per cycle while adv is high: row read, merge, write back.
// ----------------------------------------------------------------------------
module hwdf_bitmap import hwdf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    adv,
  input  bm_req_t look,
  output bm_rsp_t rsp
);

  logic [ROW_BITS-1:0] mem [BM_ROWS];
  logic [BM_ROWS-1:0]  row_valid;

  logic                req_valid;
  logic [IDX_W-1:0]    req_idx;
  logic [ROW_BITS-1:0] rd_data;
  logic                rd_vld;
  logic                fwd;
  logic [ROW_BITS-1:0] fwd_data;

  logic [ROW_W-1:0]    row_a;
  logic [ROW_W-1:0]    row_b;
  logic [COL_W-1:0]    col_b;
  logic [ROW_BITS-1:0] cur_row;
  logic [ROW_BITS-1:0] new_row;

  assign row_a   = look.idx[IDX_W-1:COL_W];
  assign row_b   = req_idx[IDX_W-1:COL_W];
  assign col_b   = req_idx[COL_W-1:0];
  assign cur_row = fwd ? fwd_data : (rd_vld ? rd_data : '0);
  assign new_row = cur_row | (ROW_BITS'(1) << col_b);

  assign rsp = '{valid: req_valid, was_set: cur_row[col_b]};

  always_ff @(posedge clk) begin
    if (adv) begin
      if (req_valid) begin
        mem[row_b] <= new_row;
      end
      rd_data  <= mem[row_a];
      fwd_data <= new_row;
      req_idx  <= look.idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      req_valid <= 1'b0;
      rd_vld    <= 1'b0;
      fwd       <= 1'b0;
    end else if (adv) begin
      if (req_valid) begin
        row_valid[row_b] <= 1'b1;
      end
      req_valid <= look.valid;
      rd_vld    <= row_valid[row_a];
      fwd       <= req_valid && (row_a == row_b);
    end
  end

endmodule

FILE: rtl/hashed_word_dedup_filter_unit.sv
// ----------------------------------------------------------------------------
// hashed_word_dedup_filter_unit
// Splits a byte stream into alphanumeric words, hashes each with djb2 and
// flags whether its bitmap bit was already set.
//
//   channel  | dir | tdata                                   | tuser/tlast
//   s_axis   | in  | [7:0] data_byte                         | tlast stream_end
//   m_axis   | out | [63:0] word_hash [71:64] word_length    | -
//            |     | [72] is_new [73] closed_by_end (zero pad)|
//
// One byte per cycle unless stalled; results pass input, request, output registers.
// Stages: input register, hash/close logic into the bitmap row read,
// test-and-set into the output register. Same-row hits are forwarded.
// All stages advance together whenever the output register is empty or taken.
// Reset clears the 64 row valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module hashed_word_dedup_filter_unit import hwdf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] data_byte
  input  logic              s_axis_tlast,   // stream_end
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [TOUT_W-1:0] m_axis_tdata    // word_hash, word_length, is_new,
                                            // closed_by_end, zero pad
);

  logic              adv;

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;

  logic [HASH_W-1:0] acc;
  logic [LEN_W-1:0]  len;
  logic              word_open;

  logic              is_char;
  logic [HASH_W-1:0] hash_ext;
  logic [LEN_W-1:0]  len_inc;
  logic              close;
  logic [HASH_W-1:0] close_hash;
  logic [LEN_W-1:0]  close_len;

  logic [HASH_W-1:0] req_hash;
  logic [LEN_W-1:0]  req_len;
  logic              req_end;

  bm_req_t           look;
  bm_rsp_t           rsp;

  logic              out_valid;
  logic [HASH_W-1:0] out_hash;
  logic [LEN_W-1:0]  out_len;
  logic              out_new;
  logic              out_end;

  assign adv           = !out_valid || m_axis_tready;
  assign s_axis_tready = adv;

  assign is_char    = is_word_char(in_byte);
  assign hash_ext   = {acc[HASH_W-6:0], 5'b0} + acc + HASH_W'(in_byte);
  assign len_inc    = (len < LEN_MAX) ? len + LEN_W'(1) : len;
  assign close      = in_valid && (is_char ? in_last : word_open);
  assign close_hash = is_char ? hash_ext : acc;
  assign close_len  = is_char ? len_inc : len;

  assign look = '{valid: close, idx: close_hash[IDX_W-1:0]};

  hwdf_bitmap u_bitmap (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .look (look),
    .rsp  (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (adv) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= HASH_SEED;
      len       <= '0;
      word_open <= 1'b0;
    end else if (adv && in_valid) begin
      if (in_last || !is_char) begin
        acc       <= HASH_SEED;
        len       <= '0;
        word_open <= 1'b0;
      end else begin
        acc       <= hash_ext;
        len       <= len_inc;
        word_open <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      req_hash <= close_hash;
      req_len  <= close_len;
      req_end  <= is_char;
      out_hash <= req_hash;
      out_len  <= req_len;
      out_new  <= !rsp.was_set;
      out_end  <= req_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= rsp.valid;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(TOUT_W - OUT_W){1'b0}}, out_end, out_new, out_len, out_hash};

`ifndef SYNTH
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    adv && in_valid && in_last |=> acc == HASH_SEED && len == '0 && !word_open)
    else $error("word state not cleared after final byte");

  a_idle_seed: assert property (@(posedge clk) disable iff (rst)
    !word_open |-> acc == HASH_SEED && len == '0)
    else $error("hash or length moved outside a word");

  a_open_len: assert property (@(posedge clk) disable iff (rst)
    word_open |-> len != '0)
    else $error("open word with zero length");

  a_out_len: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> out_len != '0)
    else $error("result with empty word");

  a_rsp_close: assert property (@(posedge clk) disable iff (rst)
    adv |=> rsp.valid == $past(close))
    else $error("bitmap lookup lost or invented");
`endif

endmodule
